// ===== hdl/sa32_pkg.sv =====
// ----------------------------------------------------------------------------
// sa32_pkg
// Opcodes, finishing codes and stage payload types of the scalar ALU.
// ----------------------------------------------------------------------------
package sa32_pkg;

	localparam logic [5:0] OP_ADD        = 6'd0;
	localparam logic [5:0] OP_ADDC       = 6'd1;
	localparam logic [5:0] OP_ADDC_CO    = 6'd2;
	localparam logic [5:0] OP_SUB        = 6'd3;
	localparam logic [5:0] OP_SUBB       = 6'd4;
	localparam logic [5:0] OP_SUBB_LT    = 6'd5;
	localparam logic [5:0] OP_MUL_LO     = 6'd6;
	localparam logic [5:0] OP_AND        = 6'd7;
	localparam logic [5:0] OP_ANDN       = 6'd8;
	localparam logic [5:0] OP_OR         = 6'd9;
	localparam logic [5:0] OP_ORN        = 6'd10;
	localparam logic [5:0] OP_XOR        = 6'd11;
	localparam logic [5:0] OP_NOT        = 6'd12;
	localparam logic [5:0] OP_SHL        = 6'd13;
	localparam logic [5:0] OP_SHR        = 6'd14;
	localparam logic [5:0] OP_SAR        = 6'd15;
	localparam logic [5:0] OP_BFM        = 6'd16;
	localparam logic [5:0] OP_BFM64_LO   = 6'd17;
	localparam logic [5:0] OP_BFM64_HI   = 6'd18;
	localparam logic [5:0] OP_ADD3       = 6'd19;
	localparam logic [5:0] OP_SHL_ADD    = 6'd20;
	localparam logic [5:0] OP_SHL_ADD_HI = 6'd21;
	localparam logic [5:0] OP_ADD_SHL    = 6'd22;
	localparam logic [5:0] OP_XOR_ADD    = 6'd23;
	localparam logic [5:0] OP_SHL_OR     = 6'd24;
	localparam logic [5:0] OP_MIN_I      = 6'd25;
	localparam logic [5:0] OP_MAX_I      = 6'd26;
	localparam logic [5:0] OP_MIN_U      = 6'd27;
	localparam logic [5:0] OP_MAX_U      = 6'd28;
	localparam logic [5:0] OP_ABS        = 6'd29;
	localparam logic [5:0] OP_BFE        = 6'd30;
	localparam logic [5:0] OP_CSEL       = 6'd31;
	localparam logic [5:0] OP_DSHL_LO    = 6'd32;
	localparam logic [5:0] OP_DSHL_HI    = 6'd33;
	localparam logic [5:0] OP_DSHR_LO    = 6'd34;
	localparam logic [5:0] OP_DSHR_HI    = 6'd35;
	localparam logic [5:0] OP_LAST       = OP_DSHR_HI;

	localparam logic [6:0] BFE_FULL_CNT  = 7'd32;

	// What the last stage does with the stage-2 payload
	typedef enum logic [1:0] {
		FIN_PASS,
		FIN_ADD_LO,
		FIN_ADD_HI,
		FIN_SHIFT
	} fin_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

	typedef struct packed {
		logic [5:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] prod;
		logic        unsup;
	} s1_t;

	typedef struct packed {
		fin_t        fin;
		logic [31:0] res;
		logic [63:0] add_x;
		logic [31:0] c;
		logic        unsup;
	} s2_t;

endpackage

// ===== hdl/sa32_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// sa32_pipe_ctl
// Valid bits and load enables of the three pipeline stages.
// ----------------------------------------------------------------------------
module sa32_pipe_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output sa32_pkg::stage_en_t en
);
	import sa32_pkg::*;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready1;
	logic ready2;
	logic ready3;

	// A stage may load when it is empty or its content moves on
	assign ready3 = !valid_s3 || !out_stall;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;

	assign en.en1    = ready1;
	assign en.en2    = ready2;
	assign en.en3    = ready3;
	assign in_stall  = !ready1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= in_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	a_free_out_never_stalls_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output side is free");

	a_transfer_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transfer not held in stage 1");

	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && out_stall) |-> in_stall)
		else $error("full pipeline took a transfer");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && out_stall) |=> valid_s3)
		else $error("stalled result dropped");

endmodule

// ===== hdl/sa32_decode.sv =====
// ----------------------------------------------------------------------------
// sa32_decode
// Stage 1: capture operands, flag unknown opcodes, form the low product.
// ----------------------------------------------------------------------------
module sa32_decode (
	input  logic          clk,
	input  logic          load,
	input  logic [5:0]    op,
	input  logic [31:0]   operand_a,
	input  logic [31:0]   operand_b,
	input  logic [31:0]   operand_c,
	output sa32_pkg::s1_t st_s1
);
	import sa32_pkg::*;

	logic [31:0] prod;

	assign prod = operand_a * operand_b;

	always_ff @(posedge clk) begin
		if (load) begin
			st_s1.op    <= op;
			st_s1.a     <= operand_a;
			st_s1.b     <= operand_b;
			st_s1.c     <= operand_c;
			st_s1.prod  <= prod;
			st_s1.unsup <= (op > OP_LAST);
		end
	end

endmodule

// ===== hdl/sa32_exec.sv =====
// ----------------------------------------------------------------------------
// sa32_exec
// Stage 2: adders, shifters, masks, compares and the single-step results.
// ----------------------------------------------------------------------------
module sa32_exec (
	input  logic          clk,
	input  logic          load,
	input  sa32_pkg::s1_t st_s1,
	output sa32_pkg::s2_t st_s2
);
	import sa32_pkg::*;

	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] c;
	logic [4:0]  s;
	logic        cin;
	logic        bin;
	logic [32:0] add33;
	logic [32:0] sub33;
	logic [31:0] shl;
	logic [31:0] shr;
	logic [31:0] sar;
	logic [63:0] shl64;
	logic [31:0] bfm32;
	logic [63:0] bfm64;
	logic [63:0] dshl;
	logic [63:0] dshr;
	logic [6:0]  cnt;
	logic [31:0] fmask;
	logic        slt_ab;
	logic        slt_ba;
	logic [31:0] res;
	fin_t        fin;
	logic [63:0] add_x;

	assign a = st_s1.a;
	assign b = st_s1.b;
	assign c = st_s1.c;
	assign s = b[4:0];

	// Carry and borrow in only where the opcode asks for them
	assign cin = (st_s1.op == OP_ADDC) || (st_s1.op == OP_ADDC_CO) ? c[0] : 1'b0;
	assign bin = (st_s1.op == OP_SUBB) || (st_s1.op == OP_SUBB_LT) ? c[0] : 1'b0;

	assign add33 = {1'b0, a} + {1'b0, b} + {32'd0, cin};
	assign sub33 = {1'b0, a} - {1'b0, b} - {32'd0, bin};

	assign shl   = a << s;
	assign shr   = a >> s;
	assign sar   = $unsigned($signed(a) >>> s);
	assign shl64 = {32'd0, a} << s;

	assign bfm32 = ((32'd1 << a[4:0]) - 32'd1) << s;
	assign bfm64 = ((64'd1 << a[5:0]) - 64'd1) << b[5:0];

	assign dshl = {b, a} << c[5:0];
	assign dshr = {b, a} >> c[5:0];

	// Field width: zero gives nothing, 32 or more keeps the whole shifted word
	assign cnt = b[22:16];
	always_comb begin
		if (cnt == 7'd0) begin
			fmask = 32'd0;
		end else if (cnt >= BFE_FULL_CNT) begin
			fmask = '1;
		end else begin
			fmask = (32'd1 << cnt[4:0]) - 32'd1;
		end
	end

	assign slt_ab = $signed(a) < $signed(b);
	assign slt_ba = $signed(b) < $signed(a);

	always_comb begin
		res   = 32'd0;
		fin   = FIN_PASS;
		add_x = {32'd0, add33[31:0]};
		case (st_s1.op)
			OP_ADD, OP_ADDC, OP_SUB, OP_SUBB: begin
				res = (st_s1.op == OP_ADD) || (st_s1.op == OP_ADDC) ?
					add33[31:0] : sub33[31:0];
			end
			OP_ADDC_CO:    res = {31'd0, add33[32]};
			OP_SUBB_LT:    res = {31'd0, sub33[32]};
			OP_MUL_LO:     res = st_s1.prod;
			OP_AND:        res = a & b;
			OP_ANDN:       res = a & ~b;
			OP_OR:         res = a | b;
			OP_ORN:        res = a | ~b;
			OP_XOR:        res = a ^ b;
			OP_NOT:        res = ~a;
			OP_SHL:        res = shl;
			OP_SHR:        res = shr;
			OP_SAR:        res = sar;
			OP_BFM:        res = bfm32;
			OP_BFM64_LO:   res = bfm64[31:0];
			OP_BFM64_HI:   res = bfm64[63:32];
			OP_ADD3:       fin = FIN_ADD_LO;
			OP_SHL_ADD: begin
				fin   = FIN_ADD_LO;
				add_x = shl64;
			end
			OP_SHL_ADD_HI: begin
				fin   = FIN_ADD_HI;
				add_x = shl64;
			end
			OP_ADD_SHL:    fin = FIN_SHIFT;
			OP_XOR_ADD: begin
				fin   = FIN_ADD_LO;
				add_x = {32'd0, a ^ b};
			end
			OP_SHL_OR:     res = shl | c;
			OP_MIN_I:      res = slt_ba ? b : a;
			OP_MAX_I:      res = slt_ab ? b : a;
			OP_MIN_U:      res = (b < a) ? b : a;
			OP_MAX_U:      res = (a < b) ? b : a;
			OP_ABS:        res = a[31] ? (~a + 32'd1) : a;
			OP_BFE:        res = shr & fmask;
			OP_CSEL:       res = (a != 32'd0) ? b : c;
			OP_DSHL_LO:    res = dshl[31:0];
			OP_DSHL_HI:    res = dshl[63:32];
			OP_DSHR_LO:    res = dshr[31:0];
			OP_DSHR_HI:    res = dshr[63:32];
			default:       res = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			st_s2.fin   <= fin;
			st_s2.res   <= res;
			st_s2.add_x <= add_x;
			st_s2.c     <= c;
			st_s2.unsup <= st_s1.unsup;
		end
	end

endmodule

// ===== hdl/sa32_finish.sv =====
// ----------------------------------------------------------------------------
// sa32_finish
// Stage 3: pass the stage-2 result, add the third operand or shift the sum, then register the result.
// ----------------------------------------------------------------------------
module sa32_finish (
	input  logic          clk,
	input  logic          load,
	input  sa32_pkg::s2_t st_s2,
	output logic [31:0]   result,
	output logic          unsupported
);
	import sa32_pkg::*;

	logic [63:0] sum64;
	logic [31:0] res;
	logic [31:0] res_s3;
	logic        unsup_s3;

	assign sum64 = st_s2.add_x + {32'd0, st_s2.c};

	always_comb begin
		case (st_s2.fin)
			FIN_PASS:   res = st_s2.res;
			FIN_ADD_LO: res = sum64[31:0];
			FIN_ADD_HI: res = sum64[63:32];
			FIN_SHIFT:  res = st_s2.add_x[31:0] << st_s2.c[4:0];
			default:    res = st_s2.res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s3   <= res;
			unsup_s3 <= st_s2.unsup;
		end
	end

	assign result      = res_s3;
	assign unsupported = unsup_s3;

endmodule

// ===== hdl/scalar_alu_32bit.sv =====
// ----------------------------------------------------------------------------
// scalar_alu_32bit
// Pipeline: three register stages (decode, execute, finish) from input transfer to result.
// Throughput: one operation per cycle unless stalled; output register holds a stalled result.
// Reset clears the stage valid bits only; operand and result registers hold garbage.
// ----------------------------------------------------------------------------
module scalar_alu_32bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  op,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic [31:0] operand_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result,
	output logic        unsupported
);
	import sa32_pkg::*;

	stage_en_t en;
	s1_t       st_s1;
	s2_t       st_s2;

	sa32_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	sa32_decode u_decode (
		.clk       (clk),
		.load      (en.en1),
		.op        (op),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.operand_c (operand_c),
		.st_s1     (st_s1)
	);

	sa32_exec u_exec (
		.clk   (clk),
		.load  (en.en2),
		.st_s1 (st_s1),
		.st_s2 (st_s2)
	);

	sa32_finish u_finish (
		.clk         (clk),
		.load        (en.en3),
		.st_s2       (st_s2),
		.result      (result),
		.unsupported (unsupported)
	);

endmodule

// ===== dv/scalar_alu_32bit_checker.sv =====
// ----------------------------------------------------------------------------
// scalar_alu_32bit_checker
// Watches both channels of the scalar ALU, computes the expected word and
// flag for every accepted operation, and compares them in order with the
// results that leave the block. Hands counts back to the testbench top.
// ----------------------------------------------------------------------------
module scalar_alu_32bit_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [5:0]        op,
	input  logic [31:0]       operand_a,
	input  logic [31:0]       operand_b,
	input  logic [31:0]       operand_c,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [31:0]       result,
	input  logic              unsupported,
	output int unsigned       mismatch_count,
	output int unsigned       outstanding,
	output int unsigned       results_checked
);
	import sa32_pkg::*;

	localparam int unsigned PRINT_CAP = 40;

	typedef struct packed {
		logic [5:0]  op;
		logic [31:0] res;
		logic        unsup;
	} alu_word_t;

	alu_word_t pending_results[$];

	function automatic alu_word_t alu_compute(logic [5:0] code, logic [31:0] a,
			logic [31:0] b, logic [31:0] c);
		alu_word_t  r;
		logic [4:0] s;
		logic [31:0] k;
		logic [32:0] wide;
		logic [63:0] dw;
		logic [6:0] cnt;
		r.op    = code;
		r.res   = '0;
		r.unsup = 1'b0;
		s       = b[4:0];
		k       = {31'd0, c[0]};
		case (code)
		OP_ADD:        r.res = a + b;
		OP_ADDC:       r.res = a + b + k;
		OP_ADDC_CO: begin
			wide  = {1'b0, a} + {1'b0, b} + {1'b0, k};
			r.res = {31'd0, wide[32]};
		end
		OP_SUB:        r.res = a - b;
		OP_SUBB:       r.res = a - b - k;
		OP_SUBB_LT: begin
			// borrow out: b + k compared at 33 bits so b = all ones with k set counts
			wide  = {1'b0, b} + {1'b0, k};
			r.res = {31'd0, wide > {1'b0, a}};
		end
		OP_MUL_LO:     r.res = a * b;
		OP_AND:        r.res = a & b;
		OP_ANDN:       r.res = a & ~b;
		OP_OR:         r.res = a | b;
		OP_ORN:        r.res = a | ~b;
		OP_XOR:        r.res = a ^ b;
		OP_NOT:        r.res = ~a;
		OP_SHL:        r.res = a << s;
		OP_SHR:        r.res = a >> s;
		OP_SAR:        r.res = $signed(a) >>> s;
		OP_BFM:        r.res = ((32'd1 << a[4:0]) - 32'd1) << s;
		OP_BFM64_LO: begin
			dw    = ((64'd1 << a[5:0]) - 64'd1) << b[5:0];
			r.res = dw[31:0];
		end
		OP_BFM64_HI: begin
			dw    = ((64'd1 << a[5:0]) - 64'd1) << b[5:0];
			r.res = dw[63:32];
		end
		OP_ADD3:       r.res = a + b + c;
		OP_SHL_ADD:    r.res = (a << s) + c;
		OP_SHL_ADD_HI: begin
			dw    = ({32'd0, a} << s) + {32'd0, c};
			r.res = dw[63:32];
		end
		OP_ADD_SHL: begin
			// wrap the sum at 32 bits before shifting
			r.res = a + b;
			r.res = r.res << c[4:0];
		end
		OP_XOR_ADD:    r.res = (a ^ b) + c;
		OP_SHL_OR:     r.res = (a << s) | c;
		OP_MIN_I:      r.res = ($signed(b) < $signed(a)) ? b : a;
		OP_MAX_I:      r.res = ($signed(a) < $signed(b)) ? b : a;
		OP_MIN_U:      r.res = (b < a) ? b : a;
		OP_MAX_U:      r.res = (a < b) ? b : a;
		OP_ABS:        r.res = a[31] ? (~a + 32'd1) : a;
		OP_BFE: begin
			cnt = b[22:16];
			if (cnt == 7'd0) begin
				r.res = '0;
			end else if (cnt >= BFE_FULL_CNT) begin
				r.res = a >> b[4:0];
			end else begin
				r.res = (a >> b[4:0]) & ((32'd1 << cnt) - 32'd1);
			end
		end
		OP_CSEL:       r.res = (a != 32'd0) ? b : c;
		OP_DSHL_LO: begin
			dw    = {b, a} << c[5:0];
			r.res = dw[31:0];
		end
		OP_DSHL_HI: begin
			dw    = {b, a} << c[5:0];
			r.res = dw[63:32];
		end
		OP_DSHR_LO: begin
			dw    = {b, a} >> c[5:0];
			r.res = dw[31:0];
		end
		OP_DSHR_HI: begin
			dw    = {b, a} >> c[5:0];
			r.res = dw[63:32];
		end
		default: begin
			r.res   = '0;
			r.unsup = 1'b1;
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [5:0] code,
			input logic [31:0] got, input logic [31:0] want);
		mismatch_count = mismatch_count + 1;
		if (mismatch_count <= PRINT_CAP) begin
			$display("ERROR: %s op=%0d got=%h want=%h at %0t", what, code, got, want,
				$realtime);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alu_word_t want;
		alu_word_t pred;
		if (!arst_n) begin
			pending_results.delete();
			mismatch_count  = 0;
			outstanding     = 0;
			results_checked = 0;
		end else begin
			// compare first: an operation accepted this edge cannot be the one leaving
			if (out_valid && !out_stall) begin
				results_checked = results_checked + 1;
				if (pending_results.size() == 0) begin
					report_mismatch("result transfer with nothing pending", '0,
						result, '0);
				end else begin
					want = pending_results.pop_front();
					if (result !== want.res) begin
						report_mismatch("result", want.op, result, want.res);
					end
					if (unsupported !== want.unsup) begin
						report_mismatch("unsupported", want.op, {31'd0, unsupported},
							{31'd0, want.unsup});
					end
				end
			end
			if (in_valid && !in_stall) begin
				pred = alu_compute(op, operand_a, operand_b, operand_c);
				pending_results = {pending_results, pred};
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== dv/scalar_alu_32bit_tb.sv =====
// ----------------------------------------------------------------------------
// scalar_alu_32bit_tb
// Drives the scalar ALU with directed corner operations and a long random
// mix of all opcodes, with bursty input traffic and a patterned output
// stall. The checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module scalar_alu_32bit_tb;
	import sa32_pkg::*;

	localparam logic [5:0] OP_FIRST_UNKNOWN = OP_LAST + 6'd1;
	localparam logic [5:0] OP_TOP_CODE      = 6'h3f;
	localparam int unsigned RANDOM_ITEMS    = 1050;
	localparam int unsigned DRAIN_CYCLES    = 10;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_SOLID
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [5:0]  op;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic [31:0] operand_c;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result;
	logic        unsupported;

	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned results_checked;

	int unsigned ops_sent;
	int unsigned unknown_sent;
	int unsigned directed_sent;
	int unsigned burst_left;
	stall_mode_t stall_mode;
	int unsigned stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	scalar_alu_32bit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.operand_c   (operand_c),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.unsupported (unsupported)
	);

	scalar_alu_32bit_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.operand_a       (operand_a),
		.operand_b       (operand_b),
		.operand_c       (operand_c),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result          (result),
		.unsupported     (unsupported),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// Output stall: switch among free, light, heavy and solid runs
	initial stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_SOLID));
			stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 12)
				: $urandom_range(1, 40);
		end
		stall_left = stall_left - 1;
		case (stall_mode)
		STALL_NONE:  out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default:     out_stall <= 1'b1;
		endcase
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
		0:       return 32'h0000_0000;
		1:       return 32'hffff_ffff;
		2:       return 32'h8000_0000;
		3:       return 32'h7fff_ffff;
		4:       return 32'h0000_0001;
		5:       return 32'($urandom_range(0, 63));
		6:       return 32'd1 << $urandom_range(0, 31);
		default: return $urandom;
		endcase
	endfunction

	// One transfer; idle gaps are inserted between bursts
	task automatic send_op(input logic [5:0] code, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] c);
		int unsigned gap_len;
		if (burst_left == 0) begin
			gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
				: $urandom_range(0, 4);
			if (gap_len > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap_len - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		in_valid  <= 1'b1;
		op        <= code;
		operand_a <= a;
		operand_b <= b;
		operand_c <= c;
		do @(posedge clk); while (in_stall);
		ops_sent = ops_sent + 1;
		if (code > OP_LAST) unknown_sent = unknown_sent + 1;
	endtask

	// Hold the input idle until every pending result has come back
	task automatic drain_results();
		@(negedge clk) in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		logic [5:0]  code;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = '0;
		operand_a    = '0;
		operand_b    = '0;
		operand_c    = '0;
		ops_sent     = 0;
		unknown_sent = 0;
		burst_left   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: every opcode at its edges, plus the named corner cases
		send_op(OP_ADD,        32'hffff_ffff, 32'h0000_0001, 32'h0000_0000);
		send_op(OP_ADDC,       32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
		send_op(OP_ADDC_CO,    32'hffff_ffff, 32'h0000_0000, 32'hffff_fffe);
		send_op(OP_ADDC_CO,    32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
		send_op(OP_SUB,        32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		send_op(OP_SUBB,       32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
		send_op(OP_SUBB_LT,    32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
		send_op(OP_MUL_LO,     32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
		send_op(OP_AND,        32'hffff_ffff, 32'ha5a5_a5a5, 32'hffff_ffff);
		send_op(OP_ANDN,       32'hffff_ffff, 32'h0000_ffff, 32'h0000_0000);
		send_op(OP_OR,         32'h0000_0000, 32'h8000_0001, 32'h0000_0000);
		send_op(OP_ORN,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_XOR,        32'hffff_ffff, 32'h5555_5555, 32'h0000_0000);
		send_op(OP_NOT,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_SHL,        32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
		send_op(OP_SHR,        32'h8000_0000, 32'hffff_ffe0, 32'h0000_0000);
		send_op(OP_SAR,        32'h8000_0000, 32'h0000_001f, 32'h0000_0000);
		send_op(OP_BFM,        32'hffff_ffff, 32'hffff_ffe1, 32'h0000_0000);
		send_op(OP_BFM64_LO,   32'h0000_003f, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_BFM64_HI,   32'hffff_ffe8, 32'hffff_ffe8, 32'h0000_0000);
		send_op(OP_ADD3,       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_op(OP_SHL_ADD,    32'hffff_ffff, 32'h0000_001f, 32'hffff_ffff);
		send_op(OP_SHL_ADD_HI, 32'hffff_ffff, 32'h0000_001f, 32'hffff_ffff);
		send_op(OP_ADD_SHL,    32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
		send_op(OP_XOR_ADD,    32'hffff_ffff, 32'h0000_0000, 32'h0000_0001);
		send_op(OP_SHL_OR,     32'h0000_0003, 32'h0000_003e, 32'h0000_0001);
		send_op(OP_MIN_I,      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_op(OP_MAX_I,      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_op(OP_MIN_U,      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_op(OP_MAX_U,      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_op(OP_ABS,        32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_op(OP_ABS,        32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
		// field extract: zero count, full count, largest count, masked count field
		send_op(OP_BFE,        32'hdead_beef, 32'h0000_0005, 32'h0000_0000);
		send_op(OP_BFE,        32'hdead_beef, 32'h0020_0004, 32'h0000_0000);
		send_op(OP_BFE,        32'hffff_ffff, 32'h007f_001f, 32'h0000_0000);
		send_op(OP_BFE,        32'hdead_beef, 32'hff85_ffe3, 32'h0000_0000);
		send_op(OP_CSEL,       32'h0000_0000, 32'hffff_ffff, 32'h1234_5678);
		send_op(OP_CSEL,       32'h8000_0000, 32'hffff_ffff, 32'h1234_5678);
		send_op(OP_DSHL_LO,    32'hffff_ffff, 32'h0000_0000, 32'h0000_003f);
		send_op(OP_DSHL_HI,    32'hffff_ffff, 32'h0000_0001, 32'h0000_0020);
		send_op(OP_DSHR_LO,    32'h8765_4321, 32'hffff_ffff, 32'hffff_ffc0);
		send_op(OP_DSHR_HI,    32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
		send_op(OP_FIRST_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_op(OP_TOP_CODE,   32'h1234_5678, 32'h0000_0001, 32'h0000_0001);
		directed_sent = ops_sent;
		drain_results();

		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				code = 6'($urandom_range(OP_FIRST_UNKNOWN, OP_TOP_CODE));
			end else begin
				code = 6'($urandom_range(OP_ADD, OP_LAST));
			end
			a = rand_operand();
			b = rand_operand();
			c = rand_operand();
			if (code == OP_BFE && $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 2))
				0:       b[22:16] = 7'd0;
				1:       b[22:16] = 7'($urandom_range(1, 31));
				default: b[22:16] = 7'($urandom_range(32, 127));
				endcase
			end
			if (code == OP_CSEL && $urandom_range(0, 1) == 0) a = '0;
			if (code == OP_SUBB_LT && $urandom_range(0, 1) == 0) begin
				// keep b near a so the borrow decision flips either way
				b = a + 32'($urandom_range(0, 2)) - 32'd1;
			end
			send_op(code, a, b, c);
			if (i == RANDOM_ITEMS / 2) drain_results();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Summary: %0d operations (%0d directed), %0d with unlisted opcodes,",
			ops_sent, directed_sent, unknown_sent);
		$display("Summary: %0d results compared under bursty input and output stall",
			results_checked);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Timeout with %0d results still pending", outstanding);
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== scalar_alu_32bit.f =====
hdl/sa32_pkg.sv
hdl/sa32_pipe_ctl.sv
hdl/sa32_decode.sv
hdl/sa32_exec.sv
hdl/sa32_finish.sv
hdl/scalar_alu_32bit.sv
dv/scalar_alu_32bit_checker.sv
dv/scalar_alu_32bit_tb.sv
